// File: hdl/srb_pkg.sv
// Shared constants and types for the sequence reorder buffer.
package srb_pkg;

	localparam int WINDOW    = 32;
	localparam int IDX_W     = $clog2(WINDOW);
	localparam int SEQ_W     = 32;
	localparam int DEV_W     = 32;
	localparam int WORD_W    = 64;

	localparam logic [SEQ_W-1:0] FIRST_EXPECTED_RST = SEQ_W'(1);
	localparam logic [IDX_W-1:0] FIRST_IDX_RST      = IDX_W'(1 % WINDOW);

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [DEV_W-1:0]  device;
		logic [WORD_W-1:0] temperature;
		logic [WORD_W-1:0] pressure;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// File: hdl/srb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/sequence_reorder_buffer.sv
// Sequence reorder buffer: holds out-of-order records in a slot window, releases them in order.
//
// Records arrive with a sequence number and are released strictly in sequence order. A record
// below the expected number, or one whose slot is already held, is taken and produces no beat.
// A record at or beyond the expected number plus WINDOW is taken and returned at once with the
// reject status. A stored record starts a drain that releases the run of records now in order,
// if any: every release is one slot lookup plus one read of the slot RAM, and waits while the
// output register is held. A new record is taken only while the buffer is idle and the output
// register is free. The last beat of a run carries last_of_run. A cfg_write reloads the
// expected number from cfg_data and clears all slots in that same cycle; the user must make it
// only while no record is in flight, and the block itself does not enforce it.
module sequence_reorder_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [srb_pkg::SEQ_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [srb_pkg::SEQ_W-1:0]   sequence_req,
	input  logic [srb_pkg::DEV_W-1:0]   device_id,
	input  logic [srb_pkg::WORD_W-1:0]  temperature_bits,
	input  logic [srb_pkg::WORD_W-1:0]  pressure_bits,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [srb_pkg::SEQ_W-1:0]   out_sequence,
	output logic [srb_pkg::DEV_W-1:0]   out_device_id,
	output logic [srb_pkg::WORD_W-1:0]  out_temperature_bits,
	output logic [srb_pkg::WORD_W-1:0]  out_pressure_bits,
	output logic                        last_of_run
);

	import srb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;

	logic [1:0]           state_q;
	logic [SEQ_W-1:0]     exp_q;
	logic [IDX_W-1:0]     eidx_q;
	logic [WINDOW-1:0]    slot_valid_q;
	logic                 out_valid_q;
	logic                 status_q;
	logic [SEQ_W-1:0]     out_sequence_q;
	logic [DEV_W-1:0]     out_device_id_q;
	logic [WORD_W-1:0]    out_temperature_q;
	logic [WORD_W-1:0]    out_pressure_q;
	logic                 last_q;

	logic             out_free;
	logic             in_ok;
	logic             below;
	logic [SEQ_W-1:0] seq_gap;
	logic             beyond;
	logic [IDX_W:0]   idx_sum;
	logic [IDX_W-1:0] in_idx;
	logic             store;
	logic             reject;
	logic [IDX_W-1:0] eidx_inc;
	logic             fetch_go;
	logic             fetch_last;
	logic             rd_en;
	slot_t            wr_slot;
	slot_t            rd_slot;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_ok    = in_valid && !in_stall;

	assign below   = sequence_req < exp_q;
	assign seq_gap = sequence_req - exp_q;
	assign beyond  = !below && (seq_gap >= SEQ_W'(WINDOW));
	assign idx_sum = {1'b0, eidx_q} + {1'b0, seq_gap[IDX_W-1:0]};
	assign in_idx  = (idx_sum >= (IDX_W+1)'(WINDOW)) ? IDX_W'(idx_sum - (IDX_W+1)'(WINDOW))
	                                                  : idx_sum[IDX_W-1:0];
	assign store   = in_ok && !below && !beyond && !slot_valid_q[in_idx];
	assign reject  = in_ok && beyond;

	always_comb begin
		if (exp_q == {SEQ_W{1'b1}} || eidx_q == IDX_W'(WINDOW - 1)) begin
			eidx_inc = '0;
		end else begin
			eidx_inc = eidx_q + IDX_W'(1);
		end
	end

	assign fetch_go   = (state_q == ST_FETCH) && out_free;
	assign fetch_last = !slot_valid_q[eidx_inc];

	assign rd_en   = (state_q == ST_DRAIN) && slot_valid_q[eidx_q];
	assign wr_slot = '{device: device_id, temperature: temperature_bits, pressure: pressure_bits};

	srb_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (WINDOW)
	) u_slot_ram (
		.clk   (clk),
		.we    (store),
		.waddr (in_idx),
		.wdata (wr_slot),
		.re    (rd_en),
		.raddr (eidx_q),
		.rdata (rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			exp_q        <= FIRST_EXPECTED_RST;
			eidx_q       <= FIRST_IDX_RST;
			slot_valid_q <= '0;
		end else if (cfg_write) begin
			state_q      <= ST_IDLE;
			exp_q        <= cfg_data;
			eidx_q       <= IDX_W'(cfg_data % SEQ_W'(WINDOW));
			slot_valid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (store) begin
						slot_valid_q[in_idx] <= 1'b1;
						state_q              <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= slot_valid_q[eidx_q] ? ST_FETCH : ST_IDLE;
				end
				ST_FETCH: begin
					if (fetch_go) begin
						slot_valid_q[eidx_q] <= 1'b0;
						exp_q                <= exp_q + SEQ_W'(1);
						eidx_q               <= eidx_inc;
						state_q              <= fetch_last ? ST_IDLE : ST_DRAIN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (reject || fetch_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reject) begin
			status_q          <= STATUS_REJECT;
			out_sequence_q    <= sequence_req;
			out_device_id_q   <= device_id;
			out_temperature_q <= temperature_bits;
			out_pressure_q    <= pressure_bits;
			last_q            <= 1'b1;
		end else if (fetch_go) begin
			status_q          <= STATUS_OK;
			out_sequence_q    <= exp_q;
			out_device_id_q   <= rd_slot.device;
			out_temperature_q <= rd_slot.temperature;
			out_pressure_q    <= rd_slot.pressure;
			last_q            <= fetch_last;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = status_q;
	assign out_sequence         = out_sequence_q;
	assign out_device_id        = out_device_id_q;
	assign out_temperature_bits = out_temperature_q;
	assign out_pressure_bits    = out_pressure_q;
	assign last_of_run          = last_q;

`ifndef SYNTHESIS
	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_REJECT) |-> last_q)
		else $error("Rejected beat is not marked as the last of its run.");

	a_release_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_OK) |-> (exp_q == out_sequence_q + SEQ_W'(1)))
		else $error("Expected number does not follow the released sequence.");

	a_idle_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !slot_valid_q[eidx_q])
		else $error("Slot of the expected number is held while idle.");

	a_fetch_slot_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> slot_valid_q[eidx_q])
		else $error("Slot read for release is not held.");
`endif

endmodule
